>>> rtl/ymfrc_pkg.sv
package ymfrc_pkg;

  localparam int unsigned LONG_FRAME_BYTES  = 1024;
  localparam int unsigned SHORT_FRAME_BYTES = 128;
  localparam int unsigned IDX_W             = 10;

  localparam logic [IDX_W-1:0] LONG_LAST_IDX  = IDX_W'(LONG_FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] SHORT_LAST_IDX = IDX_W'(SHORT_FRAME_BYTES - 1);
  localparam logic [31:0]      LONG_LEN       = 32'(LONG_FRAME_BYTES);
  localparam logic [31:0]      SHORT_LEN      = 32'(SHORT_FRAME_BYTES);

  localparam logic [7:0]  BYTE_STX  = 8'h02;
  localparam logic [7:0]  BYTE_EOT  = 8'h04;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [8:0]  PAIR_SUM  = 9'h0FF;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_NAK     = 2'd2,
    KIND_EOT     = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    PH_HEADER     = 6'b000001,
    PH_NUMBER     = 6'b000010,
    PH_COMPLEMENT = 6'b000100,
    PH_DATA       = 6'b001000,
    PH_CRC_HIGH   = 6'b010000,
    PH_CRC_LOW    = 6'b100000
  } phase_t;

  // one byte of crc-16, msb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/ymodem_frame_receiver_check_core.sv
// ymodem data-frame receiver with crc-16 check. one received serial byte is taken per
// request on the in_ stream; the block sustains one byte per clock cycle unless out_tready
// stalls it. a byte passes an input register, then the frame state update and crc step
// into the result register. payload bytes come out at once as provisional (kind payload,
// flagged when inside the still missing part of the file); the last crc byte of a frame
// yields ack or nak, and eot yields the eot reply. header, number, complement and
// crc high bytes give no result. out_tlast marks the reply that completes the transfer;
// after it every byte is swallowed until reset. the user writes file_length via cfg_wr_en
// and cfg_wr_data only while the block is idle (the block does not check); used at once.
module ymodem_frame_receiver_check_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // file_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // [7:0] payload_byte, [8] payload_in_file, rest zero
  output logic [1:0]  out_tuser,     // [1:0] result_kind
  output logic        out_tlast      // transfer_done
);

  // configuration
  logic [31:0] file_len_r;

  // input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;

  // frame state
  ymfrc_pkg::phase_t phase_r, phase_nxt;
  logic                       long_frame_r, long_frame_nxt;
  logic [ymfrc_pkg::IDX_W-1:0] data_idx_r, data_idx_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic [7:0]                 crc_high_r, crc_high_nxt;
  logic [7:0]                 number_r, number_nxt;
  logic [7:0]                 compl_r, compl_nxt;
  logic [7:0]                 expect_r, expect_nxt;
  logic [31:0]                bytes_r, bytes_nxt;
  logic                       finished_r, finished_nxt;

  // result register
  logic                 out_valid_r;
  ymfrc_pkg::kind_t     out_kind_r;
  logic [7:0]           out_byte_r;
  logic                 out_in_file_r;
  logic                 out_done_r;

  // result of the processing step
  logic                 res_valid;
  ymfrc_pkg::kind_t     res_kind;
  logic [7:0]           res_byte;
  logic                 res_in_file;
  logic                 res_done;

  logic        proc_go;
  logic [15:0] crc_in;
  logic [15:0] crc_upd;
  logic [ymfrc_pkg::IDX_W-1:0] last_idx;
  logic [31:0] frame_len;
  logic [32:0] pos_sum;
  logic [32:0] end_sum;
  logic        frame_fits;    // frame ends short of file_length
  logic        already_full;
  logic [8:0]  pair_sum;
  logic        number_ok;

  // processing step fires when the result register is free or drains this cycle
  assign proc_go   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_go;

  assign last_idx  = long_frame_r ? ymfrc_pkg::LONG_LAST_IDX : ymfrc_pkg::SHORT_LAST_IDX;
  assign frame_len = long_frame_r ? ymfrc_pkg::LONG_LEN : ymfrc_pkg::SHORT_LEN;

  // crc starts fresh on the header byte
  assign crc_in  = (phase_r == ymfrc_pkg::PH_HEADER) ? ymfrc_pkg::CRC_INIT : crc_r;
  assign crc_upd = ymfrc_pkg::crc_step(crc_in, in_byte_r);

  // index below remaining length, i.e. bytes + index < file_length
  assign pos_sum      = {1'b0, bytes_r} + {23'd0, data_idx_r};
  assign end_sum      = {1'b0, bytes_r} + {1'b0, frame_len};
  assign frame_fits   = end_sum < {1'b0, file_len_r};
  assign already_full = bytes_r >= file_len_r;

  assign pair_sum  = {1'b0, number_r} + {1'b0, compl_r};
  assign number_ok = (number_r == expect_r) && (pair_sum == ymfrc_pkg::PAIR_SUM);

  always_comb begin
    phase_nxt      = phase_r;
    long_frame_nxt = long_frame_r;
    data_idx_nxt   = data_idx_r;
    crc_nxt        = crc_r;
    crc_high_nxt   = crc_high_r;
    number_nxt     = number_r;
    compl_nxt      = compl_r;
    expect_nxt     = expect_r;
    bytes_nxt      = bytes_r;
    finished_nxt   = finished_r;
    res_valid      = 1'b0;
    res_kind       = ymfrc_pkg::KIND_PAYLOAD;
    res_byte       = 8'd0;
    res_in_file    = 1'b0;
    res_done       = 1'b0;
    if (!finished_r) begin
      case (phase_r)
        ymfrc_pkg::PH_HEADER: begin
          if (in_byte_r == ymfrc_pkg::BYTE_EOT) begin
            finished_nxt = 1'b1;
            res_valid    = 1'b1;
            res_kind     = ymfrc_pkg::KIND_EOT;
            res_done     = 1'b1;
          end else begin
            long_frame_nxt = (in_byte_r == ymfrc_pkg::BYTE_STX);
            crc_nxt        = crc_upd;
            data_idx_nxt   = '0;
            phase_nxt      = ymfrc_pkg::PH_NUMBER;
          end
        end
        ymfrc_pkg::PH_NUMBER: begin
          number_nxt = in_byte_r;
          crc_nxt    = crc_upd;
          phase_nxt  = ymfrc_pkg::PH_COMPLEMENT;
        end
        ymfrc_pkg::PH_COMPLEMENT: begin
          compl_nxt    = in_byte_r;
          crc_nxt      = crc_upd;
          data_idx_nxt = '0;
          phase_nxt    = ymfrc_pkg::PH_DATA;
        end
        ymfrc_pkg::PH_DATA: begin
          crc_nxt     = crc_upd;
          res_valid   = 1'b1;
          res_kind    = ymfrc_pkg::KIND_PAYLOAD;
          res_byte    = in_byte_r;
          res_in_file = pos_sum < {1'b0, file_len_r};
          if (data_idx_r == last_idx) begin
            data_idx_nxt = '0;
            phase_nxt    = ymfrc_pkg::PH_CRC_HIGH;
          end else begin
            data_idx_nxt = data_idx_r + ymfrc_pkg::IDX_W'(1);
          end
        end
        ymfrc_pkg::PH_CRC_HIGH: begin
          crc_high_nxt = in_byte_r;
          phase_nxt    = ymfrc_pkg::PH_CRC_LOW;
        end
        ymfrc_pkg::PH_CRC_LOW: begin
          phase_nxt    = ymfrc_pkg::PH_HEADER;
          data_idx_nxt = '0;
          res_valid    = 1'b1;
          if (!number_ok || ({crc_high_r, in_byte_r} != crc_r)) begin
            res_kind = ymfrc_pkg::KIND_NAK;
          end else begin
            res_kind   = ymfrc_pkg::KIND_ACK;
            expect_nxt = expect_r + 8'd1;
            if (frame_fits) begin
              bytes_nxt = end_sum[31:0];
            end else begin
              // file now complete: byte total clamps to the file length unless already at or past it
              bytes_nxt    = already_full ? bytes_r : file_len_r;
              finished_nxt = 1'b1;
              res_done     = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = ymfrc_pkg::PH_HEADER;
        end
      endcase
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_len_r <= 32'd1;
    end else if (cfg_wr_en) begin
      file_len_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // frame state, advanced once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ymfrc_pkg::PH_HEADER;
      long_frame_r <= 1'b0;
      data_idx_r   <= '0;
      crc_r        <= ymfrc_pkg::CRC_INIT;
      crc_high_r   <= 8'd0;
      number_r     <= 8'd0;
      compl_r      <= 8'd0;
      expect_r     <= 8'd1;
      bytes_r      <= 32'd0;
      finished_r   <= 1'b0;
    end else if (proc_go) begin
      phase_r      <= phase_nxt;
      long_frame_r <= long_frame_nxt;
      data_idx_r   <= data_idx_nxt;
      crc_r        <= crc_nxt;
      crc_high_r   <= crc_high_nxt;
      number_r     <= number_nxt;
      compl_r      <= compl_nxt;
      expect_r     <= expect_nxt;
      bytes_r      <= bytes_nxt;
      finished_r   <= finished_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_valid) begin
      out_kind_r    <= res_kind;
      out_byte_r    <= res_byte;
      out_in_file_r <= res_in_file;
      out_done_r    <= res_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_in_file_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_done_r;

  // once finished, the block stays finished until reset
  a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag dropped");

  // completion is flagged only on an ack or the eot reply
  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (out_tuser == ymfrc_pkg::KIND_ACK || out_tuser == ymfrc_pkg::KIND_EOT))
    else $error("transfer_done on wrong result kind");

  // in-file mark only on payload results
  a_in_file_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8]) |-> (out_tuser == ymfrc_pkg::KIND_PAYLOAD))
    else $error("payload_in_file set on a reply");

  // no result is produced once the transfer is finished
  a_quiet_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (finished_r && proc_go) |=> !out_valid_r)
    else $error("result after transfer finished");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

  // cycles the block may still be busy after its last reply (two-stage pipe plus margin)
  localparam int SETTLE_CYCLES = 4;
  // keep the log readable when the block is badly broken
  localparam int REPORT_CAP = 50;

  typedef enum int {
    FLAW_NONE,
    FLAW_CRC_HIGH,
    FLAW_CRC_LOW,
    FLAW_NUMBER,
    FLAW_COMPLEMENT
  } frame_flaw_t;

  typedef struct packed {
    ymfrc_pkg::kind_t kind;
    logic [7:0]       data;
    logic             in_file;
    logic             done;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // idle rates in percent, set per phase of the run
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // long receiver hold-off: the test flips stall_go, the ready process counts it down
  int stall_len = 0;
  bit stall_go = 1'b0;
  bit stall_seen = 1'b0;
  int hold_left = 0;

  int     mismatches = 0;
  int     bytes_offered = 0;
  reply_t replies_due[$];

  // receiver mirror: register, frame state and transfer counters
  logic [31:0]                 file_len_shadow = 32'd1;
  ymfrc_pkg::phase_t           rx_phase = ymfrc_pkg::PH_HEADER;
  bit                          rx_long = 1'b0;
  logic [ymfrc_pkg::IDX_W-1:0] rx_index = '0;
  logic [15:0]                 rx_crc = ymfrc_pkg::CRC_INIT;
  logic [7:0]                  crc_hi_seen = 8'h00;
  logic [7:0]                  num_seen = 8'h00;
  logic [7:0]                  cmp_seen = 8'h00;
  logic [7:0]                  next_number = 8'd1;
  logic [31:0]                 file_bytes_taken = 32'd0;
  bit                          link_closed = 1'b0;

  ymodem_frame_receiver_check_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- mirror

  // crc-16 bit by bit, data bit folded into the feedback
  function automatic logic [15:0] crc16_ccitt(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c = {c[14:0], 1'b0} ^ (fb ? ymfrc_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // part of the file still missing, zero once the register is at or below the total
  function automatic logic [31:0] bytes_missing();
    return (file_bytes_taken >= file_len_shadow) ? 32'd0 : file_len_shadow - file_bytes_taken;
  endfunction

  // append one reply to the list of replies still due
  function automatic void queue_reply(input reply_t r);
    replies_due = {replies_due, r};
  endfunction

  // advance the mirror by one accepted byte and queue the reply it causes
  function automatic void track_rx_byte(input logic [7:0] b);
    logic [31:0] span;
    logic [31:0] gain;
    logic [15:0] got;
    reply_t      r;
    r = '0;
    if (link_closed) return;
    span = rx_long ? ymfrc_pkg::LONG_LEN : ymfrc_pkg::SHORT_LEN;
    case (rx_phase)
      ymfrc_pkg::PH_HEADER: begin
        if (b == ymfrc_pkg::BYTE_EOT) begin
          link_closed = 1'b1;
          r.kind = ymfrc_pkg::KIND_EOT;
          r.done = 1'b1;
          queue_reply(r);
        end else begin
          rx_long = (b == ymfrc_pkg::BYTE_STX);
          rx_crc = crc16_ccitt(ymfrc_pkg::CRC_INIT, b);
          rx_index = '0;
          rx_phase = ymfrc_pkg::PH_NUMBER;
        end
      end
      ymfrc_pkg::PH_NUMBER: begin
        num_seen = b;
        rx_crc = crc16_ccitt(rx_crc, b);
        rx_phase = ymfrc_pkg::PH_COMPLEMENT;
      end
      ymfrc_pkg::PH_COMPLEMENT: begin
        cmp_seen = b;
        rx_crc = crc16_ccitt(rx_crc, b);
        rx_index = '0;
        rx_phase = ymfrc_pkg::PH_DATA;
      end
      ymfrc_pkg::PH_DATA: begin
        r.kind = ymfrc_pkg::KIND_PAYLOAD;
        r.data = b;
        r.in_file = (32'(rx_index) < bytes_missing());
        rx_crc = crc16_ccitt(rx_crc, b);
        if (32'(rx_index) + 32'd1 >= span) begin
          rx_index = '0;
          rx_phase = ymfrc_pkg::PH_CRC_HIGH;
        end else begin
          rx_index = rx_index + ymfrc_pkg::IDX_W'(1);
        end
        queue_reply(r);
      end
      ymfrc_pkg::PH_CRC_HIGH: begin
        crc_hi_seen = b;
        rx_phase = ymfrc_pkg::PH_CRC_LOW;
      end
      ymfrc_pkg::PH_CRC_LOW: begin
        got = {crc_hi_seen, b};
        rx_phase = ymfrc_pkg::PH_HEADER;
        rx_index = '0;
        if (num_seen != next_number ||
            (9'(num_seen) + 9'(cmp_seen)) != ymfrc_pkg::PAIR_SUM || got != rx_crc) begin
          r.kind = ymfrc_pkg::KIND_NAK;
        end else begin
          gain = (span < bytes_missing()) ? span : bytes_missing();
          file_bytes_taken = file_bytes_taken + gain;
          next_number = next_number + 8'd1;
          r.kind = ymfrc_pkg::KIND_ACK;
          r.done = (file_bytes_taken >= file_len_shadow);
          link_closed = r.done;
        end
        queue_reply(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // every reply request is matched against the oldest one due
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("unexpected result: result_kind %0d, payload_byte %0h", out_tuser,
                 out_tdata[7:0]);
      end else begin
        want = replies_due.pop_front();
        check_field("result_kind", 8'(want.kind), 8'(out_tuser));
        check_field("payload_byte", want.data, out_tdata[7:0]);
        check_field("payload_in_file", 8'(want.in_file), 8'(out_tdata[8]));
        check_field("transfer_done", 8'(want.done), 8'(out_tlast));
      end
    end
  end

  // receiver side: random idling, or a long counted hold-off when the test asks
  always @(posedge clk) begin
    if (stall_go != stall_seen) begin
      stall_seen <= stall_go;
      hold_left <= stall_len;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------- driving

  // one byte request; tvalid stays up unless the sender idles afterwards
  task automatic send_byte(input logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_rx_byte(b);
    bytes_offered++;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // sender pauses until every reply is in and the pipe has emptied
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_file_length(input logic [31:0] v);
    drain_replies();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    file_len_shadow = v;
  endtask

  // any leading byte that gives a short frame
  function automatic logic [7:0] short_head();
    logic [7:0] h;
    do h = 8'($urandom); while (h == ymfrc_pkg::BYTE_STX || h == ymfrc_pkg::BYTE_EOT);
    return h;
  endfunction

  function automatic frame_flaw_t any_flaw();
    case ($urandom_range(3))
      0: return FLAW_CRC_HIGH;
      1: return FLAW_CRC_LOW;
      2: return FLAW_NUMBER;
      default: return FLAW_COMPLEMENT;
    endcase
  endfunction

  // whole frame; fill < 0 gives random payload, cut_at rewrites file_length mid-payload
  task automatic send_frame(input logic [7:0] head, input frame_flaw_t flaw, input int fill,
                            input int cut_at = -1, input logic [31:0] cut_len = 32'd0);
    logic [7:0]  num;
    logic [7:0]  cmp;
    logic [7:0]  p;
    logic [15:0] c;
    int          span;
    span = (head == ymfrc_pkg::BYTE_STX) ? ymfrc_pkg::LONG_FRAME_BYTES :
                                           ymfrc_pkg::SHORT_FRAME_BYTES;
    num = next_number;
    if (flaw == FLAW_NUMBER) num = next_number + 8'($urandom_range(1, 255));
    cmp = ~num;
    if (flaw == FLAW_COMPLEMENT) cmp = cmp ^ 8'($urandom_range(1, 255));
    c = crc16_ccitt(ymfrc_pkg::CRC_INIT, head);
    c = crc16_ccitt(c, num);
    c = crc16_ccitt(c, cmp);
    send_byte(head);
    send_byte(num);
    send_byte(cmp);
    for (int i = 0; i < span; i++) begin
      if (i == cut_at) write_file_length(cut_len);
      p = (fill < 0) ? 8'($urandom) : 8'(fill);
      c = crc16_ccitt(c, p);
      send_byte(p);
    end
    if (flaw == FLAW_CRC_HIGH) c[15:8] = c[15:8] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_CRC_LOW) c[7:0] = c[7:0] ^ 8'($urandom_range(1, 255));
    send_byte(c[15:8]);
    send_byte(c[7:0]);
  endtask

  // garbage bytes, then filler until the block is back at a frame boundary
  task automatic send_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      // no eot (would end the session) and no long frame from noise
      if (rx_phase == ymfrc_pkg::PH_HEADER &&
          (b == ymfrc_pkg::BYTE_EOT || b == ymfrc_pkg::BYTE_STX)) b = b ^ 8'h40;
      send_byte(b);
    end
    while (rx_phase != ymfrc_pkg::PH_HEADER) send_byte(8'($urandom));
  endtask

  function automatic logic [31:0] pick_file_length();
    case ($urandom_range(5))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: return file_bytes_taken + 32'($urandom_range(0, 130));
      3: return file_bytes_taken + 32'($urandom_range(131, 1_000_000));
      4: return 32'($urandom);
      default: return file_bytes_taken - 32'($urandom_range(0, file_bytes_taken));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // register still at its reset value of one: only payload index zero is in the file
  task automatic test_reset_value();
    send_frame(short_head(), FLAW_CRC_LOW, -1);
  endtask

  // a good and a rejected frame, header and payload extremes
  task automatic test_frame_kinds();
    write_file_length(32'hFFFF_FFFF);
    send_frame(8'h01, FLAW_NONE, 8'h00);
    send_frame(8'hFF, FLAW_NUMBER, 8'hFF);
  endtask

  // mostly well-formed frames, some broken, some noise, with register changes in between
  task automatic test_random_frames(input int n);
    int          stop;
    int          roll;
    frame_flaw_t flaw;
    stop = bytes_offered + n;
    while (bytes_offered < stop) begin
      if ($urandom_range(7) == 0) write_file_length(pick_file_length());
      roll = $urandom_range(99);
      if (roll < 92) begin
        flaw = (roll < 62) ? FLAW_NONE : any_flaw();
        // a good frame must not complete the file before the end of the run
        if (flaw == FLAW_NONE && bytes_missing() <= ymfrc_pkg::SHORT_LEN) flaw = any_flaw();
        send_frame(short_head(), flaw, -1);
      end else begin
        send_noise($urandom_range(1, 40));
      end
    end
  endtask

  // marking of payload bytes against the missing part of the file
  task automatic test_file_length_edges();
    // register raised in the middle of the payload takes effect at once
    write_file_length(file_bytes_taken + 32'd40);
    send_frame(short_head(), FLAW_NONE, -1, 64, file_bytes_taken + 32'd5000);
    write_file_length(32'hFFFF_FFFF);
  endtask

  // receiver holds off while a frame keeps coming, so the input has to stall
  task automatic test_backpressure();
    write_file_length(32'hFFFF_FFFF);
    stall_len = 600;
    stall_go = ~stall_go;
    send_frame(short_head(), FLAW_NONE, -1);
    drain_replies();
  endtask

  // one closing path per seed, then everything after it must be swallowed
  task automatic test_finish();
    case ($urandom_range(2))
      0: send_byte(ymfrc_pkg::BYTE_EOT);
      1: begin
        // last frame reaches or passes the end of the file
        write_file_length(file_bytes_taken +
                          32'($urandom_range(1, ymfrc_pkg::SHORT_FRAME_BYTES)));
        send_frame(short_head(), FLAW_NONE, -1);
      end
      default: begin
        // register at or below the total: next good frame closes with nothing added
        write_file_length(32'($urandom_range(0, file_bytes_taken)));
        send_frame(short_head(), FLAW_NONE, -1);
      end
    endcase
    send_byte(ymfrc_pkg::BYTE_EOT);
    send_byte(ymfrc_pkg::BYTE_STX);
    repeat (30) send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles a little, receiver a lot
    tx_idle_pct = 13;
    rx_idle_pct = 53;
    test_reset_value();
    test_frame_kinds();
    test_random_frames(130);

    // and the other way round
    tx_idle_pct = 53;
    rx_idle_pct = 13;
    test_file_length_edges();
    test_backpressure();

    // full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_finish();

    drain_replies();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
